// ----- src/llta_pkg.sv -----
// Shared types and constants of the least-loaded token admission block.
package llta_pkg;

	localparam int MaxDevices = 8;
	localparam int DevW       = $clog2(MaxDevices);
	localparam int CountW     = 4;
	localparam int TokW       = 8;
	localparam int SumW       = 11;
	localparam int KindW      = 2;
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = 8;

	localparam logic [KindW-1:0] KIND_GPU = 2'd0;
	localparam logic [KindW-1:0] KIND_CPU = 2'd1;
	localparam logic [KindW-1:0] KIND_REL = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_ACTIVE = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_TOKENS = 2'd1;

	localparam logic [CountW-1:0] MaxDevCount = CountW'(MaxDevices);

	typedef struct packed {
		logic [CountW-1:0] n;
		logic [TokW-1:0]   cap;
		logic [SumW-1:0]   total;
	} llta_cfg_t;

	typedef struct packed {
		logic            en;
		logic [DevW-1:0] idx;
		logic [TokW-1:0] data;
	} llta_wr_t;

endpackage

// ----- src/llta_bank.sv -----
// Per-device free-token counters with one read and one write port.
module llta_bank (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   reload,
	input  logic [llta_pkg::TokW-1:0] reload_val,
	input  logic [llta_pkg::DevW-1:0] rd_idx,
	output logic [llta_pkg::TokW-1:0] rd_data,
	input  llta_pkg::llta_wr_t     wr
);
	import llta_pkg::*;

	logic [TokW-1:0] free_q [MaxDevices];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxDevices; i++) free_q[i] <= TokW'(1);
		end else if (reload) begin
			for (int i = 0; i < MaxDevices; i++) free_q[i] <= reload_val;
		end else if (wr.en) begin
			free_q[wr.idx] <= wr.data;
		end
	end

	assign rd_data = free_q[rd_idx];

endmodule

// ----- src/llta_alu.sv -----
// Shared scan unit: running-sum adder and greater-than compare.
module llta_alu (
	input  logic [llta_pkg::SumW-1:0] acc,
	input  logic [llta_pkg::TokW-1:0] val,
	input  logic [llta_pkg::TokW-1:0] best,
	output logic [llta_pkg::SumW-1:0] acc_next,
	output logic                      gt
);
	import llta_pkg::*;

	logic [TokW:0] diff;

	assign acc_next = acc + SumW'(val);
	assign diff     = {1'b0, best} - {1'b0, val};
	assign gt       = diff[TokW];

endmodule

// ----- src/llta_seq.sv -----
// Sequencer: scans the counters, applies the update and registers the result word.
module llta_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  llta_pkg::llta_cfg_t        cfg,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [llta_pkg::KindW-1:0] kind,
	input  logic [3:0]                 release_target,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic                       granted,
	output logic                       has_device,
	output logic [2:0]                 assigned_device,
	output logic                       any_available,
	output logic [10:0]                tokens_in_use,
	output logic [10:0]                total_capacity,
	output logic [llta_pkg::DevW-1:0]  rd_idx,
	input  logic [llta_pkg::TokW-1:0]  rd_data,
	output llta_pkg::llta_wr_t         wr
);
	import llta_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_DONE} state_t;

	state_t            state_q;
	logic [KindW-1:0]  kind_q;
	logic [3:0]        target_q;
	logic [DevW-1:0]   idx_q;
	logic [TokW-1:0]   best_q;
	logic [DevW-1:0]   dev_q;
	logic              found_q;
	logic [SumW-1:0]   sum_q;
	logic              rsp_valid_q;
	logic              granted_q;
	logic              has_dev_q;
	logic [2:0]        dev_out_q;
	logic              any_q;
	logic [10:0]       in_use_q;
	logic [10:0]       total_q;

	logic [SumW-1:0]   acc_next;
	logic              gt;
	logic              last;
	logic              take;
	logic              give;
	logic              rel_in_range;

	llta_alu u_alu (
		.acc      (sum_q),
		.val      (rd_data),
		.best     (best_q),
		.acc_next (acc_next),
		.gt       (gt)
	);

	assign last         = ({1'b0, idx_q} == (cfg.n - CountW'(1)));
	assign rel_in_range = (target_q < cfg.n);
	assign take         = (kind_q == KIND_GPU) && found_q;
	assign give         = (kind_q == KIND_REL) && rel_in_range && (rd_data < cfg.cap);

	always_comb begin
		rd_idx  = idx_q;
		wr.en   = 1'b0;
		wr.idx  = dev_q;
		wr.data = rd_data - TokW'(1);
		if (state_q == S_APPLY) begin
			if (kind_q == KIND_REL) begin
				rd_idx  = target_q[DevW-1:0];
				wr.idx  = target_q[DevW-1:0];
				wr.data = rd_data + TokW'(1);
				wr.en   = give;
			end else begin
				rd_idx = dev_q;
				wr.en  = take;
			end
		end
	end

	assign req_ready       = (state_q == S_IDLE);
	assign rsp_valid       = rsp_valid_q;
	assign granted         = granted_q;
	assign has_device      = has_dev_q;
	assign assigned_device = dev_out_q;
	assign any_available   = any_q;
	assign tokens_in_use   = in_use_q;
	assign total_capacity  = total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= KIND_GPU;
			target_q    <= '0;
			idx_q       <= '0;
			best_q      <= '0;
			dev_q       <= '0;
			found_q     <= 1'b0;
			sum_q       <= '0;
			rsp_valid_q <= 1'b0;
			granted_q   <= 1'b0;
			has_dev_q   <= 1'b0;
			dev_out_q   <= '0;
			any_q       <= 1'b0;
			in_use_q    <= '0;
			total_q     <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && (state_q != S_DONE)) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						kind_q   <= kind;
						target_q <= release_target;
						idx_q    <= '0;
						best_q   <= '0;
						dev_q    <= '0;
						found_q  <= 1'b0;
						sum_q    <= '0;
						state_q  <= (cfg.n != '0) ? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					sum_q <= acc_next;
					if (gt) begin
						best_q  <= rd_data;
						dev_q   <= idx_q;
						found_q <= 1'b1;
					end
					if (last) state_q <= S_APPLY;
					else      idx_q   <= idx_q + DevW'(1);
				end
				S_APPLY: begin
					if (take)      sum_q <= sum_q - SumW'(1);
					else if (give) sum_q <= sum_q + SumW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						granted_q   <= (kind_q == KIND_CPU) ||
						               ((kind_q == KIND_GPU) && ((cfg.n == '0) || found_q));
						has_dev_q   <= take;
						dev_out_q   <= take ? dev_q : '0;
						any_q       <= (cfg.n == '0) || (sum_q != '0);
						in_use_q    <= cfg.total - sum_q;
						total_q     <= cfg.total;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- src/least_loaded_token_admission.sv -----
// Least-loaded token admission: config registers, counter bank and sequencer.
//
//   channel   signals                                    role
//   cfg       cfg_we, cfg_index, cfg_data                register write, no wait
//   req       req_valid/req_ready, kind, release_target  request word in
//   rsp       rsp_valid/rsp_ready, granted .. total      result word out
//
// A request holds the block while it scans the N gated devices (1..8), one counter
// per cycle through the shared scan unit, then the update and result register.
// With no gated devices it skips the scan and the update.
// Reset loads every counter with 1, gating off. A config write to the active or tokens register reloads all counters.
// A finished result waits in the output register; a new request is taken meanwhile,
// and only the final hand-off stalls until rsp_ready frees the register.
module least_loaded_token_admission (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [llta_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [llta_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [1:0]                    kind,
	input  logic [3:0]                    release_target,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic                          granted,
	output logic                          has_device,
	output logic [2:0]                    assigned_device,
	output logic                          any_available,
	output logic [10:0]                   tokens_in_use,
	output logic [10:0]                   total_capacity
);
	import llta_pkg::*;

	logic [CountW-1:0] active_q;
	logic [TokW-1:0]   tokens_q;
	llta_cfg_t         cfg;
	logic              reload;
	logic [TokW-1:0]   reload_val;
	logic [DevW-1:0]   rd_idx;
	logic [TokW-1:0]   rd_data;
	llta_wr_t          wr;
	logic [CountW+TokW-1:0] prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			tokens_q <= TokW'(1);
		end else if (cfg_we) begin
			if (cfg_index == REG_ACTIVE) active_q <= cfg_data[CountW-1:0];
			if (cfg_index == REG_TOKENS) tokens_q <= cfg_data[TokW-1:0];
		end
	end

	assign cfg.n     = (active_q > MaxDevCount) ? MaxDevCount : active_q;
	assign cfg.cap   = (tokens_q == '0) ? TokW'(1) : tokens_q;
	assign prod      = cfg.n * cfg.cap;
	assign cfg.total = prod[SumW-1:0];

	assign reload     = cfg_we && ((cfg_index == REG_ACTIVE) || (cfg_index == REG_TOKENS));
	assign reload_val = (cfg_index == REG_TOKENS) ?
	                    ((cfg_data[TokW-1:0] == '0) ? TokW'(1) : cfg_data[TokW-1:0]) :
	                    cfg.cap;

	llta_bank u_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.reload     (reload),
		.reload_val (reload_val),
		.rd_idx     (rd_idx),
		.rd_data    (rd_data),
		.wr         (wr)
	);

	llta_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.kind            (kind),
		.release_target  (release_target),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.granted         (granted),
		.has_device      (has_device),
		.assigned_device (assigned_device),
		.any_available   (any_available),
		.tokens_in_use   (tokens_in_use),
		.total_capacity  (total_capacity),
		.rd_idx          (rd_idx),
		.rd_data         (rd_data),
		.wr              (wr)
	);

endmodule
